>>> design/i2cbb_pkg.sv
// Shared types, register indexes and timing helpers for the I2C bit-bang master.
package i2cbb_pkg;

   localparam int DELAY_WIDTH = 10;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 10;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SDA_SETUP   = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SCL_HIGH    = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SCL_LOW     = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_HOLD  = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ACK_WAIT    = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RETRY_LIMIT = 3'd5;

   typedef enum logic [2:0] {
      OP_NONE     = 3'd0,
      OP_START    = 3'd1,
      OP_REPSTART = 3'd2,
      OP_STOP     = 3'd3,
      OP_WRITE    = 3'd4,
      OP_READ     = 3'd5,
      OP_ACK      = 3'd6,
      OP_ADDR     = 3'd7
   } op_type;

   typedef struct packed {
      logic [DELAY_WIDTH-1:0] sda_setup;
      logic [DELAY_WIDTH-1:0] scl_high;
      logic [DELAY_WIDTH-1:0] scl_low;
      logic [DELAY_WIDTH-1:0] start_hold;
      logic [DELAY_WIDTH-1:0] ack_wait;
      logic [3:0]             retry_limit;
   } cfg_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] data;
      logic       send_ack;
      logic       sda_sample;
   } cmd_type;

   typedef struct packed {
      logic       scl;
      logic       sda;
      logic       ready;
      logic       done;
      logic       ack;
      logic [7:0] rdata;
   } rsp_type;

   // A segment of N ticks loads N-1; a zero setting still lasts one tick.
   function automatic logic [DELAY_WIDTH-1:0] load_ticks(input logic [DELAY_WIDTH-1:0] v);
      logic [DELAY_WIDTH-1:0] r;
      r = (v == '0) ? '0 : v - DELAY_WIDTH'(1);
      return r;
   endfunction

endpackage

>>> design/i2cbb_front.sv
// Front end: accepts tick items, classifies the command and queues them for the sequencer.
module i2cbb_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  logic [2:0]          req_operation,
   input  logic [7:0]          req_data_byte,
   input  logic                req_send_ack,
   input  logic                req_sda_sample,
   output logic                cmd_valid,
   output i2cbb_pkg::cmd_type  cmd_head,
   input  logic                cmd_take
);

   i2cbb_pkg::cmd_type cmd_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push;
   logic       do_pop;
   i2cbb_pkg::cmd_type decoded;

   always_comb begin
      decoded.op         = i2cbb_pkg::op_type'(req_operation);
      decoded.data       = req_data_byte;
      decoded.send_ack   = req_send_ack;
      decoded.sda_sample = req_sda_sample;
   end

   assign req_full  = (count_ff == 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd_head  = cmd_ff[rd_ptr_ff];
   assign do_push   = req_push && !req_full;
   assign do_pop    = cmd_take && cmd_valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         cmd_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

>>> design/i2cbb_seq.sv
// Back end: the bus sequencer, one tick per queued item, with a two-entry result queue.
module i2cbb_seq (
   input  logic                clock,
   input  logic                reset,
   input  i2cbb_pkg::cfg_type  cfg,
   input  logic                cmd_valid,
   input  i2cbb_pkg::cmd_type  cmd_head,
   output logic                cmd_take,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output i2cbb_pkg::rsp_type  rsp_head
);

   typedef enum logic [27:0] {
      PH_IDLE    = 28'h0000001,
      PH_ST_SDA  = 28'h0000002,
      PH_ST_SCL  = 28'h0000004,
      PH_RS_SDA  = 28'h0000008,
      PH_RS_SCL  = 28'h0000010,
      PH_SP_SDA  = 28'h0000020,
      PH_SP_SCL  = 28'h0000040,
      PH_SP_REL  = 28'h0000080,
      PH_WR_BIT  = 28'h0000100,
      PH_WR_HI   = 28'h0000200,
      PH_WR_WAIT = 28'h0000400,
      PH_WR_LO   = 28'h0000800,
      PH_RD_REL  = 28'h0001000,
      PH_RD_HI   = 28'h0002000,
      PH_RD_LO   = 28'h0004000,
      PH_AK_SET  = 28'h0008000,
      PH_AK_HI   = 28'h0010000,
      PH_AK_LO   = 28'h0020000,
      PH_AW_BIT  = 28'h0040000,
      PH_AW_HI   = 28'h0080000,
      PH_AW_WAIT = 28'h0100000,
      PH_AW_LO   = 28'h0200000,
      PH_ASP_SDA = 28'h0400000,
      PH_ASP_SCL = 28'h0800000,
      PH_ASP_REL = 28'h1000000,
      PH_AGAP    = 28'h2000000,
      PH_AST_SDA = 28'h4000000,
      PH_AST_SCL = 28'h8000000
   } phase_type;

   phase_type phase_ff, phase_in, target;
   logic [i2cbb_pkg::DELAY_WIDTH-1:0] tick_ff, tick_in;
   logic [3:0] bit_ff, bit_in;
   logic [7:0] shift_ff, shift_in;
   logic [3:0] attempt_ff, attempt_in;
   logic       scl_ff, scl_in;
   logic       sda_ff, sda_in;
   logic       ack_ff, ack_in;
   logic       go;
   logic       ready;
   logic       done;
   logic       step;

   i2cbb_pkg::rsp_type rsp_ff [2];
   i2cbb_pkg::rsp_type rsp_new;
   logic       rwr_ptr_ff, rwr_ptr_in;
   logic       rrd_ptr_ff, rrd_ptr_in;
   logic [1:0] rcount_ff, rcount_in;
   logic       rsp_deq;

   // A tick runs whenever one is queued and the result has somewhere to go.
   assign step     = cmd_valid && (rcount_ff != 2'd2);
   assign cmd_take = step;

   always_comb begin
      phase_in   = phase_ff;
      tick_in    = tick_ff;
      bit_in     = bit_ff;
      shift_in   = shift_ff;
      attempt_in = attempt_ff;
      scl_in     = scl_ff;
      sda_in     = sda_ff;
      ack_in     = ack_ff;
      ready      = 1'b0;
      done       = 1'b0;
      go         = 1'b0;
      target     = PH_IDLE;

      if (step) begin
         if (phase_ff == PH_IDLE) begin
            ready = 1'b1;
            unique case (cmd_head.op)
               i2cbb_pkg::OP_START: begin
                  go = 1'b1; target = PH_ST_SDA;
               end
               i2cbb_pkg::OP_REPSTART: begin
                  go = 1'b1; target = PH_RS_SDA;
               end
               i2cbb_pkg::OP_STOP: begin
                  go = 1'b1; target = PH_SP_SDA;
               end
               i2cbb_pkg::OP_WRITE: begin
                  shift_in = cmd_head.data; bit_in = 4'd0;
                  go = 1'b1; target = PH_WR_BIT;
               end
               i2cbb_pkg::OP_READ: begin
                  shift_in = 8'd0; bit_in = 4'd0;
                  go = 1'b1; target = PH_RD_REL;
               end
               i2cbb_pkg::OP_ACK: begin
                  if (cmd_head.send_ack) sda_in = 1'b0;
                  go = 1'b1; target = PH_AK_SET;
               end
               i2cbb_pkg::OP_ADDR: begin
                  shift_in = cmd_head.data; bit_in = 4'd0; attempt_in = 4'd0;
                  go = 1'b1; target = PH_AW_BIT;
               end
               default: ;
            endcase
         end else if (tick_ff != '0) begin
            tick_in = tick_ff - i2cbb_pkg::DELAY_WIDTH'(1);
         end else begin
            go = 1'b1;
            unique case (phase_ff)
               PH_ST_SDA:  target = PH_ST_SCL;
               PH_RS_SDA:  target = PH_RS_SCL;
               PH_RS_SCL:  target = PH_ST_SDA;
               PH_SP_SDA:  target = PH_SP_SCL;
               PH_SP_SCL:  target = PH_SP_REL;
               PH_WR_BIT:  target = PH_WR_HI;
               PH_AW_BIT:  target = PH_AW_HI;
               PH_WR_HI, PH_AW_HI: begin
                  if (bit_ff < 4'd8) begin
                     target = (phase_ff == PH_AW_HI) ? PH_AW_LO : PH_WR_LO;
                  end else if (cfg.ack_wait != '0) begin
                     target = (phase_ff == PH_AW_HI) ? PH_AW_WAIT : PH_WR_WAIT;
                  end else begin
                     ack_in = !cmd_head.sda_sample;
                     target = (phase_ff == PH_AW_HI) ? PH_AW_LO : PH_WR_LO;
                  end
               end
               PH_WR_WAIT: begin
                  ack_in = !cmd_head.sda_sample;
                  target = PH_WR_LO;
               end
               PH_AW_WAIT: begin
                  ack_in = !cmd_head.sda_sample;
                  target = PH_AW_LO;
               end
               PH_WR_LO: begin
                  if (bit_ff < 4'd8) begin
                     bit_in = bit_ff + 4'd1;
                     target = PH_WR_BIT;
                  end else begin
                     done = 1'b1;
                  end
               end
               PH_AW_LO: begin
                  if (bit_ff < 4'd8) begin
                     bit_in = bit_ff + 4'd1;
                     target = PH_AW_BIT;
                  end else if (!ack_ff && (attempt_ff < cfg.retry_limit)) begin
                     attempt_in = attempt_ff + 4'd1;
                     target = PH_ASP_SDA;
                  end else begin
                     done = 1'b1;
                  end
               end
               PH_RD_REL:  target = PH_RD_HI;
               PH_RD_HI: begin
                  shift_in = {shift_ff[6:0], cmd_head.sda_sample};
                  target = PH_RD_LO;
               end
               PH_RD_LO: begin
                  bit_in = bit_ff + 4'd1;
                  if (bit_in < 4'd8) target = PH_RD_HI;
                  else done = 1'b1;
               end
               PH_AK_SET:  target = PH_AK_HI;
               PH_AK_HI:   target = PH_AK_LO;
               PH_ASP_SDA: target = PH_ASP_SCL;
               PH_ASP_SCL: target = PH_ASP_REL;
               PH_ASP_REL: target = PH_AGAP;
               PH_AGAP:    target = PH_AST_SDA;
               PH_AST_SDA: target = PH_AST_SCL;
               PH_AST_SCL: begin
                  bit_in = 4'd0;
                  target = PH_AW_BIT;
               end
               default:    done = 1'b1;
            endcase
         end
      end

      // Entering a segment sets its line levels and loads its duration.
      if (go) begin
         phase_in = target;
         unique case (target)
            PH_ST_SDA, PH_AST_SDA: begin
               sda_in = 1'b0; tick_in = i2cbb_pkg::load_ticks(cfg.start_hold);
            end
            PH_ST_SCL, PH_AST_SCL, PH_WR_LO, PH_AW_LO, PH_RD_LO, PH_AK_LO: begin
               scl_in = 1'b0; tick_in = i2cbb_pkg::load_ticks(cfg.scl_low);
            end
            PH_RS_SDA, PH_RD_REL: begin
               sda_in = 1'b1; tick_in = i2cbb_pkg::load_ticks(cfg.sda_setup);
            end
            PH_RS_SCL, PH_SP_SCL, PH_ASP_SCL, PH_WR_HI, PH_AW_HI, PH_RD_HI, PH_AK_HI: begin
               scl_in = 1'b1; tick_in = i2cbb_pkg::load_ticks(cfg.scl_high);
            end
            PH_SP_SDA, PH_ASP_SDA: begin
               sda_in = 1'b0; tick_in = i2cbb_pkg::load_ticks(cfg.sda_setup);
            end
            PH_SP_REL, PH_ASP_REL: begin
               sda_in = 1'b1; tick_in = i2cbb_pkg::load_ticks(cfg.start_hold);
            end
            PH_AGAP: begin
               tick_in = i2cbb_pkg::load_ticks(cfg.start_hold);
            end
            PH_WR_BIT, PH_AW_BIT: begin
               sda_in  = (bit_in < 4'd8) ? shift_in[3'd7 - bit_in[2:0]] : 1'b1;
               tick_in = i2cbb_pkg::load_ticks(cfg.sda_setup);
            end
            PH_WR_WAIT, PH_AW_WAIT: begin
               tick_in = i2cbb_pkg::load_ticks(cfg.ack_wait);
            end
            PH_AK_SET: begin
               tick_in = i2cbb_pkg::load_ticks(cfg.sda_setup);
            end
            default: begin
               phase_in = PH_IDLE; tick_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         tick_ff    <= '0;
         bit_ff     <= 4'd0;
         shift_ff   <= 8'd0;
         attempt_ff <= 4'd0;
         scl_ff     <= 1'b1;
         sda_ff     <= 1'b1;
         ack_ff     <= 1'b0;
      end else if (step) begin
         phase_ff   <= phase_in;
         tick_ff    <= tick_in;
         bit_ff     <= bit_in;
         shift_ff   <= shift_in;
         attempt_ff <= attempt_in;
         scl_ff     <= scl_in;
         sda_ff     <= sda_in;
         ack_ff     <= ack_in;
      end
   end

   // Result queue.
   always_comb begin
      rsp_new.scl   = scl_in;
      rsp_new.sda   = sda_in;
      rsp_new.ready = ready;
      rsp_new.done  = done;
      rsp_new.ack   = ack_in;
      rsp_new.rdata = shift_in;
   end

   assign rsp_empty = (rcount_ff == 2'd0);
   assign rsp_head  = rsp_ff[rrd_ptr_ff];
   assign rsp_deq   = rsp_pop && !rsp_empty;

   always_comb begin
      rwr_ptr_in = step ? !rwr_ptr_ff : rwr_ptr_ff;
      rrd_ptr_in = rsp_deq ? !rrd_ptr_ff : rrd_ptr_ff;
      rcount_in  = rcount_ff + {1'b0, step} - {1'b0, rsp_deq};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rwr_ptr_ff <= 1'b0;
         rrd_ptr_ff <= 1'b0;
         rcount_ff  <= 2'd0;
      end else begin
         rwr_ptr_ff <= rwr_ptr_in;
         rrd_ptr_ff <= rrd_ptr_in;
         rcount_ff  <= rcount_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff[rwr_ptr_ff] <= rsp_new;
      end
   end

endmodule

>>> design/i2c_bitbang_master.sv
// Top level of the I2C bit-bang master: timing registers and the front/back pipeline.
//
// This block is an open-drain I2C master sequencer in which every transfer on the request
// queue is one timing tick. A tick carries an optional command (start, repeated start, stop,
// write byte, read byte, ack/nak, or address with retries) together with the SDA level
// sampled in that tick; a command is taken only on a tick where the sequencer is idle and is
// otherwise ignored. Each tick yields exactly one transfer on the result queue giving the SCL
// and SDA release levels, whether the command was taken, whether a command finished, the last
// acknowledge seen and the shift register. The block takes one tick per clock cycle while the
// result queue has room; the front end queues up to two ticks and the sequencer up to two
// results, so a stall on either side stops the other only once a queue is full.
// Segment lengths come from the timing registers in tick units and are written through the csr
// port, which is always ready; write them only while the block has no ticks in flight.

module i2c_bitbang_master (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [i2cbb_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [i2cbb_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   input  logic                                  req_push,
   output logic                                  req_full,
   input  logic [2:0]                            req_operation,
   input  logic [7:0]                            req_data_byte,
   input  logic                                  req_send_ack,
   input  logic                                  req_sda_sample,
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output logic                                  rsp_scl_release,
   output logic                                  rsp_sda_release,
   output logic                                  rsp_ready_res,
   output logic                                  rsp_op_done,
   output logic                                  rsp_ack_received,
   output logic [7:0]                            rsp_read_data
);

   i2cbb_pkg::cfg_type cfg_ff, cfg_in;
   i2cbb_pkg::cmd_type cmd_head;
   i2cbb_pkg::rsp_type rsp_head;
   logic               cmd_valid;
   logic               cmd_take;

   // The register file never stalls a write.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            i2cbb_pkg::CSR_SDA_SETUP:   cfg_in.sda_setup   = csr_wdata;
            i2cbb_pkg::CSR_SCL_HIGH:    cfg_in.scl_high    = csr_wdata;
            i2cbb_pkg::CSR_SCL_LOW:     cfg_in.scl_low     = csr_wdata;
            i2cbb_pkg::CSR_START_HOLD:  cfg_in.start_hold  = csr_wdata;
            i2cbb_pkg::CSR_ACK_WAIT:    cfg_in.ack_wait    = csr_wdata;
            i2cbb_pkg::CSR_RETRY_LIMIT: cfg_in.retry_limit = csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sda_setup   <= i2cbb_pkg::DELAY_WIDTH'(3);
         cfg_ff.scl_high    <= i2cbb_pkg::DELAY_WIDTH'(4);
         cfg_ff.scl_low     <= i2cbb_pkg::DELAY_WIDTH'(2);
         cfg_ff.start_hold  <= i2cbb_pkg::DELAY_WIDTH'(4);
         cfg_ff.ack_wait    <= i2cbb_pkg::DELAY_WIDTH'(8);
         cfg_ff.retry_limit <= 4'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   i2cbb_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_operation  (req_operation),
      .req_data_byte  (req_data_byte),
      .req_send_ack   (req_send_ack),
      .req_sda_sample (req_sda_sample),
      .cmd_valid      (cmd_valid),
      .cmd_head       (cmd_head),
      .cmd_take       (cmd_take)
   );

   i2cbb_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (cmd_valid),
      .cmd_head  (cmd_head),
      .cmd_take  (cmd_take),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_head  (rsp_head)
   );

   assign rsp_scl_release  = rsp_head.scl;
   assign rsp_sda_release  = rsp_head.sda;
   assign rsp_ready_res    = rsp_head.ready;
   assign rsp_op_done      = rsp_head.done;
   assign rsp_ack_received = rsp_head.ack;
   assign rsp_read_data    = rsp_head.rdata;

endmodule
